FILE: src/kfd_pkg.sv
// Shared constants for the KISS frame deframer: special byte codes,
// field widths and frame error codes. No dependencies.
`default_nettype none

package kfd_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned ERR_W  = 2;
	localparam int unsigned USER_W = ERR_W + 1;

	localparam logic [BYTE_W-1:0] FEND  = 8'hC0;
	localparam logic [BYTE_W-1:0] FESC  = 8'hDB;
	localparam logic [BYTE_W-1:0] TFEND = 8'hDC;
	localparam logic [BYTE_W-1:0] TFESC = 8'hDD;
	localparam logic [BYTE_W-1:0] CMD_DATA = 8'h00;

	typedef enum logic [ERR_W-1:0] {
		ERR_NONE    = 2'd0,
		ERR_BAD_ESC = 2'd1,
		ERR_ESC_END = 2'd2
	} frame_err_t;

endpackage

`default_nettype wire

FILE: src/kiss_frame_deframer_core.sv
// KISS frame deframer top level: input register, byte decoder and result
// register in one pass. Depends on kfd_pkg.
//
// Usage:
//   Slave stream (s_tvalid/s_tready/s_tdata) takes one raw byte from the
//   serial link per request. Master stream (m_tvalid/m_tready/m_tdata/
//   m_tlast/m_tuser) gives decoded payload, with m_tlast on the last result
//   of each data frame. A byte produces zero or one result.
//   Bytes are ignored until the first frame end. Escape pairs are undone,
//   the command byte is stripped, non-data frames are dropped silently.
//   Payload leaves one byte late so the final byte carries m_tlast; a
//   data frame with no payload gives one marker with byte_present low.
//   Throughput: one byte per cycle while no stall holds it (see Stall).
//   Path: a taken byte sits in the input register and its result, if any,
//   is loaded into the result register, which drives m_tvalid, once free.
//   The per-byte decoder and frame state loop sit between the two.
//   Reset: all control state clears; the block hunts for a frame end.
//   Stall: while m_tready is low and a result waits, the input register
//   holds one more byte, then s_tready drops until the result is taken.
`default_nettype none

module kiss_frame_deframer_core (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       s_tvalid,
	output      logic                       s_tready,
	input  wire logic [kfd_pkg::BYTE_W-1:0] s_tdata,  // [7:0] rx_byte
	output      logic                       m_tvalid,
	input  wire logic                       m_tready,
	output      logic [kfd_pkg::BYTE_W-1:0] m_tdata,  // [7:0] payload_byte
	output      logic                       m_tlast,  // frame_end
	output      logic [kfd_pkg::USER_W-1:0] m_tuser   // [0] byte_present, [2:1] frame_error
);

	typedef enum logic [1:0] {
		PH_HUNT,
		PH_CMD,
		PH_DATA,
		PH_DISCARD
	} phase_t;

	logic                       in_valid_s1;
	logic [kfd_pkg::BYTE_W-1:0] in_byte_s1;

	phase_t                     phase_q;
	logic                       esc_q;
	logic [kfd_pkg::BYTE_W-1:0] held_q;
	logic                       held_valid_q;

	logic                       out_valid_q;
	logic [kfd_pkg::BYTE_W-1:0] out_byte_q;
	logic                       out_present_q;
	logic                       out_end_q;
	logic [kfd_pkg::ERR_W-1:0]  out_err_q;

	logic                       out_free;
	logic                       advance;
	logic                       in_take;

	phase_t                     phase_n;
	logic                       esc_n;
	logic [kfd_pkg::BYTE_W-1:0] held_n;
	logic                       held_valid_n;
	logic                       emit;
	logic [kfd_pkg::BYTE_W-1:0] r_byte;
	logic                       r_present;
	logic                       r_end;
	logic [kfd_pkg::ERR_W-1:0]  r_err;
	logic [kfd_pkg::BYTE_W-1:0] dec;
	logic                       bad_esc;

	assign out_free = !out_valid_q || m_tready;
	assign advance  = in_valid_s1 && out_free;
	assign s_tready = !in_valid_s1 || advance;
	assign in_take  = s_tvalid && s_tready;

	always_comb begin
		phase_n      = phase_q;
		esc_n        = esc_q;
		held_n       = held_q;
		held_valid_n = held_valid_q;
		emit         = 1'b0;
		r_byte       = held_valid_q ? held_q : '0;
		r_present    = held_valid_q;
		r_end        = 1'b1;
		r_err        = kfd_pkg::ERR_NONE;
		dec          = in_byte_s1;
		bad_esc      = 1'b0;

		if (esc_q) begin
			case (in_byte_s1)
				kfd_pkg::TFEND: dec = kfd_pkg::FEND;
				kfd_pkg::TFESC: dec = kfd_pkg::FESC;
				default:        bad_esc = 1'b1;
			endcase
		end

		if (phase_q == PH_HUNT) begin
			if (in_byte_s1 == kfd_pkg::FEND) begin
				phase_n      = PH_CMD;
				esc_n        = 1'b0;
				held_valid_n = 1'b0;
			end
		end else if (in_byte_s1 == kfd_pkg::FEND) begin
			if (phase_q == PH_DATA) begin
				emit  = 1'b1;
				r_err = esc_q ? kfd_pkg::ERR_ESC_END : kfd_pkg::ERR_NONE;
			end
			phase_n      = PH_CMD;
			esc_n        = 1'b0;
			held_valid_n = 1'b0;
		end else if (bad_esc) begin
			if (phase_q == PH_DATA) begin
				emit  = 1'b1;
				r_err = kfd_pkg::ERR_BAD_ESC;
			end
			phase_n      = PH_HUNT;
			esc_n        = 1'b0;
			held_valid_n = 1'b0;
		end else if (!esc_q && in_byte_s1 == kfd_pkg::FESC) begin
			esc_n = 1'b1;
		end else begin
			esc_n = 1'b0;
			case (phase_q)
				PH_CMD: begin
					phase_n      = (dec == kfd_pkg::CMD_DATA) ? PH_DATA : PH_DISCARD;
					held_valid_n = 1'b0;
				end
				PH_DATA: begin
					emit         = held_valid_q;
					r_present    = 1'b1;
					r_byte       = held_q;
					r_end        = 1'b0;
					held_n       = dec;
					held_valid_n = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1  <= 1'b0;
			phase_q      <= PH_HUNT;
			esc_q        <= 1'b0;
			held_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (in_take) begin
				in_valid_s1 <= 1'b1;
				in_byte_s1  <= s_tdata;
			end else if (advance) begin
				in_valid_s1 <= 1'b0;
			end
			if (advance) begin
				phase_q      <= phase_n;
				esc_q        <= esc_n;
				held_q       <= held_n;
				held_valid_q <= held_valid_n;
			end
			if (out_free) begin
				out_valid_q <= advance && emit;
			end
			if (advance && emit) begin
				out_byte_q    <= r_byte;
				out_present_q <= r_present;
				out_end_q     <= r_end;
				out_err_q     <= r_end ? r_err : kfd_pkg::ERR_NONE;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tlast  = out_end_q;
	assign m_tuser  = {out_err_q, out_present_q};

	a_empty_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> (m_tdata == '0 && m_tlast))
		else $error("marker without end or with nonzero data");

	a_mid_frame_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tlast) |-> (m_tuser == {kfd_pkg::ERR_NONE, 1'b1}))
		else $error("mid-frame result carries error or no data");

	a_close_clears_held: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && emit && r_end) |=> (!held_valid_q && phase_q != PH_DATA))
		else $error("held byte survives frame close");

	a_hunt_nothing_held: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_HUNT) |-> !held_valid_q)
		else $error("held byte while hunting");

endmodule

`default_nettype wire
